// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the binomial coefficient unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bcu_pkg.sv
// Types, constants and state encoding of the binomial coefficient unit.
package bcu_pkg;

   localparam int ROW_IN_W    = 6;
   localparam int COEF_W      = 31;
   localparam int ENTRY_W     = 32;
   localparam int MAX_ROW_DEF = 63;

   localparam logic [COEF_W-1:0]  COEF_MAX  = {COEF_W{1'b1}};
   localparam logic [ENTRY_W-1:0] OVER_MARK = {1'b1, {(ENTRY_W-1){1'b0}}};

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_COL_GT_ROW = 2'd1;
   localparam logic [1:0] STATUS_SATURATED  = 2'd2;

   typedef struct packed {
      logic [ROW_IN_W-1:0] row_n;
      logic [ROW_IN_W-1:0] column_k;
   } bcu_req_type;

   typedef struct packed {
      logic [COEF_W-1:0] coefficient;
      logic [1:0]        status;
   } bcu_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_READ,
      ST_ADD,
      ST_FINAL_RD,
      ST_RESP
   } bcu_state_type;

endpackage

// File: rtl/bcu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bcu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bcu_cap_add.sv
// Shared adder that caps its sum at the overflow mark.
module bcu_cap_add import bcu_pkg::*; (
   input  logic [ENTRY_W-1:0] a,
   input  logic [ENTRY_W-1:0] b,
   output logic [ENTRY_W-1:0] sum
);

   logic [ENTRY_W:0] raw_sum;

   assign raw_sum = {1'b0, a} + {1'b0, b};
   assign sum     = (raw_sum > {1'b0, OVER_MARK}) ? OVER_MARK : raw_sum[ENTRY_W-1:0];

endmodule

// File: rtl/binomial_coefficient_unit.sv
// Top level: sequencer that builds one triangle row at a time with a shared adder.
//
//   channel  ports                       direction  handshake
//   request  start, busy, req_data       in         start & !busy
//   response rsp_valid, rsp_data         out        rsp_valid, one cycle
//
// The single adder and the one-port read of the scratch row RAM set the pace: each
// column takes a read state and then an add state, and no new item is taken while busy.
// An item with column greater than row is answered in the next cycle.
// Reset is synchronous and clears the sequencer and the response strobe only.
// The scratch row needs no clearing: each entry is written before it is read.
// The receiver cannot stall; the response shows for exactly one cycle.
module binomial_coefficient_unit import bcu_pkg::*; #(
   parameter int MAX_ROW = MAX_ROW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  bcu_req_type req_data,
   output logic        rsp_valid,
   output bcu_rsp_type rsp_data
);

   localparam int ROW_W = $clog2(MAX_ROW + 1);

   bcu_state_type state_ff, state_in;

   logic [ROW_W-1:0]   n_ff, n_in;
   logic [ROW_W-1:0]   k_ff, k_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ROW_W-1:0]   col_ff, col_in;
   logic [ENTRY_W-1:0] prev_ff, prev_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bcu_rsp_type        rsp_ff, rsp_in;

   logic [ROW_W-1:0]   n_clamp;
   logic               reject;
   logic [ROW_W-1:0]   col_end;
   logic               col_last;
   logic [ENTRY_W-1:0] old_val;
   logic [ENTRY_W-1:0] add_sum;

   logic               wr_en;
   logic [ROW_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ROW_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   // Clamp the row before comparing the column against it.
   assign n_clamp = (req_data.row_n > ROW_IN_W'(MAX_ROW)) ? ROW_W'(MAX_ROW)
                                                          : ROW_W'(req_data.row_n);
   assign reject  = req_data.column_k > ROW_IN_W'(n_clamp);

   // Columns beyond k never feed C(n,k); stop each row at min(r,k).
   assign col_end  = (row_ff < k_ff) ? row_ff : k_ff;
   assign col_last = col_ff == col_end;
   // The diagonal entry is new in this row: read it as zero.
   assign old_val  = (col_ff == row_ff) ? '0 : rd_data;

   bcu_cap_add u_cap_add (
      .a   (old_val),
      .b   (prev_ff),
      .sum (add_sum)
   );

   bcu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ROW + 1)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !reject) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            state_in = (n_ff == '0) ? ST_FINAL_RD : ST_READ;
         end
         ST_READ: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (col_last && row_ff == n_ff) begin
               state_in = ST_FINAL_RD;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FINAL_RD: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      n_in         = n_ff;
      k_in         = k_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      prev_in      = prev_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = col_ff;
      wr_data      = add_sum;
      rd_en        = 1'b0;
      rd_addr      = col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in = n_clamp;
               k_in = ROW_W'(req_data.column_k);
               if (reject) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.coefficient = '0;
                  rsp_in.status      = STATUS_COL_GT_ROW;
               end
            end
         end
         ST_INIT: begin
            // Row zero holds a single one.
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = ENTRY_W'(1);
            row_in  = ROW_W'(1);
            col_in  = '0;
            prev_in = '0;
         end
         ST_READ: begin
            rd_en = 1'b1;
         end
         ST_ADD: begin
            wr_en   = 1'b1;
            prev_in = old_val;
            if (col_last) begin
               row_in  = row_ff + ROW_W'(1);
               col_in  = '0;
               prev_in = '0;
            end else begin
               col_in = col_ff + ROW_W'(1);
            end
         end
         ST_FINAL_RD: begin
            rd_en   = 1'b1;
            rd_addr = k_ff;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            if (rd_data[ENTRY_W-1]) begin
               rsp_in.coefficient = COEF_MAX;
               rsp_in.status      = STATUS_SATURATED;
            end else begin
               rsp_in.coefficient = rd_data[COEF_W-1:0];
               rsp_in.status      = STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      k_ff    <= k_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      prev_ff <= prev_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/bcu_checker.sv
// Port-level checker for the binomial coefficient unit, bound to the top level.
`include "assert_macros.svh"

module bcu_checker import bcu_pkg::*; #(
   parameter int MAX_ROW = MAX_ROW_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input bcu_req_type req_data,
   input logic        rsp_valid,
   input bcu_rsp_type rsp_data
);

   logic [ROW_IN_W-1:0] n_clamp;
   logic                reject;
   logic                take_reject;
   logic                take_build;
   logic                rsp_reject;
   logic                rsp_sat;
   logic                rsp_ok;

   assign n_clamp = (req_data.row_n > ROW_IN_W'(MAX_ROW)) ? ROW_IN_W'(MAX_ROW)
                                                          : req_data.row_n;
   assign reject  = req_data.column_k > n_clamp;

   assign take_reject = start && !busy && reject;
   assign take_build  = start && !busy && !reject;
   assign rsp_reject  = rsp_valid && rsp_data.status == STATUS_COL_GT_ROW;
   assign rsp_sat     = rsp_valid && rsp_data.status == STATUS_SATURATED;
   assign rsp_ok      = rsp_valid && rsp_data.status == STATUS_OK;

   `BCU_ASSERT_NEXT(a_reject_answers, take_reject, rsp_reject, "reject not answered next cycle")
   `BCU_ASSERT_NEXT(a_accept_goes_busy, take_build, busy && !rsp_valid, "beat did not start work")
   `BCU_ASSERT_IMP(a_reject_zero, rsp_reject, rsp_data.coefficient == '0, "reject with nonzero value")
   `BCU_ASSERT_IMP(a_sat_max, rsp_sat, rsp_data.coefficient == COEF_MAX, "saturation below maximum")
   `BCU_ASSERT_IMP(a_ok_nonzero, rsp_ok, rsp_data.coefficient != '0, "valid coefficient of zero")

endmodule

bind binomial_coefficient_unit bcu_checker #(.MAX_ROW(MAX_ROW)) u_bcu_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench of the binomial coefficient unit: directed table, then random beats.
module tb_top import bcu_pkg::*; ();

   localparam int MAX_ROW    = MAX_ROW_DEF;
   localparam int N_DIRECTED = 21;
   localparam int N_RANDOM   = 730;
   localparam int QUIET_LO   = 300;
   localparam int QUIET_HI   = 450;

   typedef struct {
      logic [ROW_IN_W-1:0] row_n;
      logic [ROW_IN_W-1:0] column_k;
      bit                  fixed;
      logic [COEF_W-1:0]   coefficient;
      logic [1:0]          status;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   bcu_req_type req_data;
   logic        rsp_valid;
   bcu_rsp_type rsp_data;

   // Expected result typed into the table, travels with the beat being driven.
   bit          fixed_pending;
   bcu_rsp_type fixed_rsp;

   bcu_rsp_type pending_coefficients[$];
   int          mismatch_count = 0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{6'd0,  6'd0,  1'b1, 31'd1,    STATUS_OK},
      '{6'd0,  6'd63, 1'b1, 31'd0,    STATUS_COL_GT_ROW},
      '{6'd62, 6'd63, 1'b1, 31'd0,    STATUS_COL_GT_ROW},
      '{6'd0,  6'd1,  1'b1, 31'd0,    STATUS_COL_GT_ROW},
      '{6'd21, 6'd42, 1'b1, 31'd0,    STATUS_COL_GT_ROW},
      '{6'd1,  6'd0,  1'b1, 31'd1,    STATUS_OK},
      '{6'd1,  6'd1,  1'b1, 31'd1,    STATUS_OK},
      '{6'd63, 6'd0,  1'b1, 31'd1,    STATUS_OK},
      '{6'd63, 6'd63, 1'b1, 31'd1,    STATUS_OK},
      '{6'd63, 6'd1,  1'b1, 31'd63,   STATUS_OK},
      '{6'd63, 6'd62, 1'b1, 31'd63,   STATUS_OK},
      '{6'd34, 6'd17, 1'b1, COEF_MAX, STATUS_SATURATED},
      '{6'd63, 6'd31, 1'b1, COEF_MAX, STATUS_SATURATED},
      '{6'd63, 6'd32, 1'b1, COEF_MAX, STATUS_SATURATED},
      '{6'd42, 6'd21, 1'b1, COEF_MAX, STATUS_SATURATED},
      '{6'd33, 6'd16, 1'b0, 31'd0,    STATUS_OK},
      '{6'd34, 6'd16, 1'b0, 31'd0,    STATUS_OK},
      '{6'd32, 6'd16, 1'b0, 31'd0,    STATUS_OK},
      '{6'd31, 6'd15, 1'b0, 31'd0,    STATUS_OK},
      '{6'd20, 6'd10, 1'b0, 31'd0,    STATUS_OK},
      '{6'd5,  6'd2,  1'b0, 31'd0,    STATUS_OK}
   };

   binomial_coefficient_unit #(.MAX_ROW(MAX_ROW)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Build the triangle row by row; entries cap at the overflow mark so sums never wrap.
   function automatic bcu_rsp_type binomial_of(bcu_req_type item);
      logic [ENTRY_W-1:0] row_vals [0:63];
      logic [ENTRY_W:0]   sum;
      bcu_rsp_type        result;
      int                 n_eff;
      int                 k_eff;
      n_eff = (int'(item.row_n) > MAX_ROW) ? MAX_ROW : int'(item.row_n);
      k_eff = int'(item.column_k);
      if (k_eff > n_eff) begin
         result.coefficient = '0;
         result.status      = STATUS_COL_GT_ROW;
         return result;
      end
      for (int c = 0; c < 64; c++) row_vals[c] = '0;
      row_vals[0] = ENTRY_W'(1);
      for (int r = 1; r <= n_eff; r++) begin
         row_vals[r] = ENTRY_W'(1);
         for (int c = r - 1; c >= 1; c--) begin
            sum = {1'b0, row_vals[c]} + {1'b0, row_vals[c-1]};
            row_vals[c] = (sum > {1'b0, OVER_MARK}) ? OVER_MARK : sum[ENTRY_W-1:0];
         end
      end
      if (row_vals[k_eff] > {1'b0, COEF_MAX}) begin
         result.coefficient = COEF_MAX;
         result.status      = STATUS_SATURATED;
      end else begin
         result.coefficient = row_vals[k_eff][COEF_W-1:0];
         result.status      = STATUS_OK;
      end
      return result;
   endfunction

   // Record each accepted beat, then match each response against the oldest expectation.
   always @(posedge clock) begin : check_beats
      bcu_rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            if (fixed_pending) pending_coefficients.push_back(fixed_rsp);
            else pending_coefficients.push_back(binomial_of(req_data));
         end
         if (rsp_valid) begin
            if (pending_coefficients.size() == 0) begin
               $display("%0t: unexpected response coefficient %0d status %0d",
                        $time, rsp_data.coefficient, rsp_data.status);
               mismatch_count++;
            end else begin
               want = pending_coefficients.pop_front();
               if (rsp_data.coefficient !== want.coefficient) begin
                  $display("%0t: coefficient expected %0d actual %0d",
                           $time, want.coefficient, rsp_data.coefficient);
                  mismatch_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : drive_beats
      stim_row_type row;
      bit           quiet;
      int           pick;
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      fixed_pending = 1'b0;
      fixed_rsp     = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int idx = 0; idx < N_DIRECTED + N_RANDOM; idx++) begin
         if (idx < N_DIRECTED) begin
            row = directed_rows[idx];
         end else begin
            row.fixed = 1'b0;
            pick = $urandom_range(99);
            // Keep most rows short; large rows are slow to build.
            if (pick < 10) begin
               row.row_n    = ROW_IN_W'($urandom_range(62));
               row.column_k = ROW_IN_W'($urandom_range(63, int'(row.row_n) + 1));
            end else if (pick < 70) begin
               row.row_n    = ROW_IN_W'($urandom_range(15));
               row.column_k = ROW_IN_W'($urandom_range(int'(row.row_n)));
            end else if (pick < 90) begin
               row.row_n    = ROW_IN_W'($urandom_range(40, 16));
               row.column_k = ROW_IN_W'($urandom_range(int'(row.row_n)));
            end else begin
               row.row_n    = ROW_IN_W'($urandom_range(63));
               row.column_k = ROW_IN_W'($urandom_range(63));
            end
         end
         quiet = (idx >= QUIET_LO) && (idx < QUIET_HI);
         while (!quiet && $urandom_range(99) < 23) begin
            start <= 1'b0;
            @(posedge clock);
         end
         start         <= 1'b1;
         req_data      <= '{row_n: row.row_n, column_k: row.column_k};
         fixed_pending <= row.fixed;
         fixed_rsp     <= '{coefficient: row.coefficient, status: row.status};
         // Hold the beat until the unit takes it.
         do @(posedge clock); while (busy);
      end
      start <= 1'b0;
      while (pending_coefficients.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_coefficients.size() == 0) begin
         $display("binomial_coefficient_unit regression: pass");
      end else begin
         $display("binomial_coefficient_unit regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #60000000;
      $display("binomial_coefficient_unit regression: fail");
      $finish;
   end

endmodule
